/* sv/efr_pkg.sv */
// Shared types, codes and controller/datapath command structs for the rasterizer.
package efr_pkg;

    typedef struct packed {
        logic        operation;
        logic [1:0]  vertex_slot;
        logic [10:0] vertex_x;
        logic [10:0] vertex_y;
        logic [31:0] vertex_color;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [31:0] pixel_color;
        logic        last_position;
    } out_beat_t;

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_STEP    = 1'b1;
    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NO_TRI  = 2'd2;
    localparam logic [1:0] SLOT_LAST  = 2'd2;
    localparam logic [1:0] SLOT_NONE  = 2'd3;
    localparam logic [1:0] CHAN_LAST  = 2'd3;
    localparam logic [3:0] DIV_TOP    = 4'd8;

    typedef struct packed {
        logic       vtx_we;
        logic [1:0] vtx_slot;
        logic       su_prod;
        logic       su_area;
        logic       su_edge;
        logic       su_esum;
        logic       c_mul;
        logic       c_sum;
        logic       c_init;
        logic       c_row;
        logic [1:0] chan;
        logic       walk_start;
        logic       step_acc;
        logic       div_iter;
        logic [3:0] div_bit;
        logic       out_color;
    } cmd_t;

    typedef struct packed {
        logic area_zero;
        logic area_neg;
        logic walk_active;
        logic in_tri;
    } sts_t;

endpackage

/* sv/efr_ctrl.sv */
// Sequencer for setup, traversal steps and the colour division.
module efr_ctrl import efr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  sts_t     sts,
    output cmd_t     cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_AREA  = 4'd2;
    localparam logic [3:0] S_EDGE  = 4'd3;
    localparam logic [3:0] S_ESUM  = 4'd4;
    localparam logic [3:0] S_CMUL  = 4'd5;
    localparam logic [3:0] S_CSUM  = 4'd6;
    localparam logic [3:0] S_CINIT = 4'd7;
    localparam logic [3:0] S_CROW  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DOUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       cull_reg;
    logic       acc;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign s_ready   = (state_reg == S_IDLE)
                     && (!m_valid_reg || m_ready || s_data.operation == OP_LOAD);
    assign acc       = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        cmd.vtx_slot = s_data.vertex_slot;
        cmd.chan     = chan_reg;
        cmd.div_bit  = cnt_reg;
        state_next   = state_reg;
        chan_next    = chan_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    if (s_data.operation == OP_LOAD) begin
                        cmd.vtx_we = (s_data.vertex_slot != SLOT_NONE);
                        if (s_data.vertex_slot == SLOT_LAST) begin
                            state_next = S_PROD;
                        end
                    end else begin
                        cmd.step_acc = 1'b1;
                        if (sts.walk_active && sts.in_tri) begin
                            state_next = S_DIV;
                            cnt_next   = DIV_TOP;
                        end else begin
                            m_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_PROD: begin
                cmd.su_prod = 1'b1;
                state_next  = S_AREA;
            end
            S_AREA: begin
                cmd.su_area = 1'b1;
                state_next  = S_EDGE;
            end
            S_EDGE: begin
                if (sts.area_zero || (sts.area_neg && cull_reg)) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.su_edge = 1'b1;
                    state_next  = S_ESUM;
                end
            end
            S_ESUM: begin
                cmd.su_esum = 1'b1;
                chan_next   = '0;
                state_next  = S_CMUL;
            end
            S_CMUL: begin
                cmd.c_mul  = 1'b1;
                state_next = S_CSUM;
            end
            S_CSUM: begin
                cmd.c_sum  = 1'b1;
                state_next = S_CINIT;
            end
            S_CINIT: begin
                cmd.c_init = 1'b1;
                state_next = S_CROW;
            end
            S_CROW: begin
                cmd.c_row = 1'b1;
                if (chan_reg == CHAN_LAST) begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_CMUL;
                end
            end
            S_DIV: begin
                cmd.div_iter = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DOUT;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_DOUT: begin
                cmd.out_color = 1'b1;
                m_valid_next  = 1'b1;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            chan_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            cull_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cull_reg <= cfg_data;
            end
        end
    end

endmodule

/* sv/efr_datapath.sv */
// Vertex store, setup arithmetic, edge/colour walkers and four-lane divider.
module efr_datapath import efr_pkg::*; #(
    parameter int COORD_BITS = 11
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_data,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_beat_t m_data
);

    localparam int CW   = COORD_BITS;
    localparam int PW   = 2 * CW;
    localparam int CCW  = 2 * CW + 1;
    localparam int AW   = 2 * CW + 3;
    localparam int SW   = CW + 1;
    localparam int EW   = 2 * CW + 4;
    localparam int KPW  = CW + 10;
    localparam int KCPW = 2 * CW + 10;
    localparam int KAW  = CW + 12;
    localparam int KCW  = 2 * CW + 12;
    localparam int IPW  = KAW + SW;
    localparam int NW   = 2 * CW + 14;
    localparam int NXT [3] = '{1, 2, 0};

    logic [CW-1:0]         vx_reg [3];
    logic [CW-1:0]         vy_reg [3];
    logic [31:0]           vc_reg [3];
    logic [PW-1:0]         pxy_reg [3];
    logic [PW-1:0]         pyx_reg [3];
    logic signed [SW-1:0]  sx_reg [3];
    logic signed [SW-1:0]  sy_reg [3];
    logic signed [SW-1:0]  sxf [3];
    logic signed [SW-1:0]  syf [3];
    logic [CW-1:0]         xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [CW-1:0]         xmin_c, xmax_c, ymin_c, ymax_c;
    logic signed [CCW-1:0] cc_reg [3];
    logic signed [CCW-1:0] ccw [3];
    logic signed [CCW-1:0] ccf [3];
    logic signed [AW-1:0]  area_reg;
    logic signed [2*SW-1:0] pex_reg [3];
    logic signed [2*SW-1:0] pey_reg [3];
    logic signed [EW-1:0]  erow_reg [3];
    logic signed [EW-1:0]  ecur_reg [3];
    logic signed [8:0]     cs [3];
    logic signed [8:0]     dc [3];
    logic signed [KPW-1:0] pa_reg [3];
    logic signed [KPW-1:0] pb_reg [3];
    logic signed [KCPW-1:0] pc_reg [3];
    logic signed [KAW-1:0] ka_reg [4];
    logic signed [KAW-1:0] kb_reg [4];
    logic signed [KCW-1:0] kc_reg;
    logic signed [IPW-1:0] pia_reg, pib_reg;
    logic signed [NW-1:0]  nrow_reg [4];
    logic signed [NW-1:0]  ncur_reg [4];
    logic [AW-1:0]         den_reg;
    logic [NW-1:0]         rem_reg [4];
    logic [8:0]            q_reg [4];
    logic                  neg_reg [4];
    logic [CW-1:0]         curx_reg, cury_reg;
    logic                  span_reg, active_reg;
    logic                  in_tri, row_done, last;
    logic [31:0]           color;
    logic [NW-1:0]         dsh;
    out_beat_t             out_reg;

    function automatic logic [7:0] chan_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    // bounding box of the three stored vertices
    always_comb begin
        xmin_c = vx_reg[0];
        xmax_c = vx_reg[0];
        ymin_c = vy_reg[0];
        ymax_c = vy_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (vx_reg[i] < xmin_c) xmin_c = vx_reg[i];
            if (vx_reg[i] > xmax_c) xmax_c = vx_reg[i];
            if (vy_reg[i] < ymin_c) ymin_c = vy_reg[i];
            if (vy_reg[i] > ymax_c) ymax_c = vy_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ccw[i] = $signed({1'b0, pxy_reg[i]}) - $signed({1'b0, pyx_reg[i]});
            ccf[i] = area_reg[AW-1] ? -cc_reg[i] : cc_reg[i];
            sxf[i] = area_reg[AW-1] ? -sx_reg[i] : sx_reg[i];
            syf[i] = area_reg[AW-1] ? -sy_reg[i] : sy_reg[i];
            cs[i]  = $signed({1'b0, chan_byte(vc_reg[i], cmd.chan)});
        end
        dc[0] = cs[2] - cs[1];
        dc[1] = cs[0] - cs[2];
        dc[2] = cs[1] - cs[0];
    end

    assign in_tri   = !ecur_reg[0][EW-1] && !ecur_reg[1][EW-1] && !ecur_reg[2][EW-1];
    assign row_done = (curx_reg >= xmax_reg) || (!in_tri && span_reg);
    assign last     = row_done && (cury_reg >= ymax_reg);
    assign dsh      = NW'(den_reg) << cmd.div_bit;

    always_comb begin
        color = '0;
        for (int k = 0; k < 4; k++) begin
            color[8*(3-k) +: 8] = neg_reg[k] ? 8'd0 : (q_reg[k][8] ? 8'hFF : q_reg[k][7:0]);
        end
    end

    // vertex store and setup
    always_ff @(posedge aclk) begin
        if (cmd.vtx_we) begin
            vx_reg[cmd.vtx_slot] <= CW'(s_data.vertex_x);
            vy_reg[cmd.vtx_slot] <= CW'(s_data.vertex_y);
            vc_reg[cmd.vtx_slot] <= s_data.vertex_color;
        end
        if (cmd.su_prod) begin
            for (int i = 0; i < 3; i++) begin
                pxy_reg[i] <= PW'(vx_reg[i]) * PW'(vy_reg[NXT[i]]);
                pyx_reg[i] <= PW'(vx_reg[NXT[i]]) * PW'(vy_reg[i]);
                sx_reg[i]  <= $signed({1'b0, vy_reg[i]}) - $signed({1'b0, vy_reg[NXT[i]]});
                sy_reg[i]  <= $signed({1'b0, vx_reg[NXT[i]]}) - $signed({1'b0, vx_reg[i]});
            end
            xmin_reg <= xmin_c;
            xmax_reg <= xmax_c;
            ymin_reg <= ymin_c;
            ymax_reg <= ymax_c;
        end
        if (cmd.su_area) begin
            for (int i = 0; i < 3; i++) begin
                cc_reg[i] <= ccw[i];
            end
            area_reg <= AW'(ccw[0]) + AW'(ccw[1]) + AW'(ccw[2]);
        end
        if (cmd.su_edge) begin
            for (int i = 0; i < 3; i++) begin
                sx_reg[i]  <= sxf[i];
                sy_reg[i]  <= syf[i];
                pex_reg[i] <= (2*SW)'(sxf[i]) * (2*SW)'($signed({1'b0, xmin_reg}));
                pey_reg[i] <= (2*SW)'(syf[i]) * (2*SW)'($signed({1'b0, ymin_reg}));
            end
        end
        if (cmd.c_mul) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= KPW'($signed({1'b0, vy_reg[i]})) * KPW'(dc[i]);
                pb_reg[i] <= KPW'($signed({1'b0, vx_reg[i]})) * KPW'(dc[i]);
                pc_reg[i] <= KCPW'(cs[i]) * KCPW'(cc_reg[NXT[i]]);
            end
        end
        if (cmd.c_sum) begin
            ka_reg[cmd.chan] <= KAW'(pa_reg[0]) + KAW'(pa_reg[1]) + KAW'(pa_reg[2]);
            kb_reg[cmd.chan] <= -(KAW'(pb_reg[0]) + KAW'(pb_reg[1]) + KAW'(pb_reg[2]));
            kc_reg <= KCW'(pc_reg[0]) + KCW'(pc_reg[1]) + KCW'(pc_reg[2]);
        end
        if (cmd.c_init) begin
            pia_reg <= IPW'(ka_reg[cmd.chan]) * IPW'($signed({1'b0, xmin_reg}));
            pib_reg <= IPW'(kb_reg[cmd.chan]) * IPW'($signed({1'b0, ymin_reg}));
        end
    end

    // walkers: edge values, colour numerators, cursor
    always_ff @(posedge aclk) begin
        if (cmd.su_esum) begin
            for (int i = 0; i < 3; i++) begin
                erow_reg[i] <= EW'(pex_reg[i]) + EW'(pey_reg[i]) + EW'(ccf[i]);
                ecur_reg[i] <= EW'(pex_reg[i]) + EW'(pey_reg[i]) + EW'(ccf[i]);
            end
        end
        if (cmd.c_row) begin
            nrow_reg[cmd.chan] <= NW'(pia_reg) + NW'(pib_reg) + NW'(kc_reg);
            ncur_reg[cmd.chan] <= NW'(pia_reg) + NW'(pib_reg) + NW'(kc_reg);
        end
        if (cmd.walk_start) begin
            curx_reg <= xmin_reg;
            cury_reg <= ymin_reg;
        end
        if (cmd.step_acc && active_reg && !last) begin
            if (!row_done) begin
                curx_reg <= curx_reg + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    ecur_reg[i] <= ecur_reg[i] + EW'(sx_reg[i]);
                end
                for (int k = 0; k < 4; k++) begin
                    ncur_reg[k] <= ncur_reg[k] + NW'(ka_reg[k]);
                end
            end else begin
                curx_reg <= xmin_reg;
                cury_reg <= cury_reg + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    erow_reg[i] <= erow_reg[i] + EW'(sy_reg[i]);
                    ecur_reg[i] <= erow_reg[i] + EW'(sy_reg[i]);
                end
                for (int k = 0; k < 4; k++) begin
                    nrow_reg[k] <= nrow_reg[k] + NW'(kb_reg[k]);
                    ncur_reg[k] <= nrow_reg[k] + NW'(kb_reg[k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            span_reg   <= 1'b0;
        end else begin
            if (cmd.vtx_we && cmd.vtx_slot == SLOT_LAST) begin
                active_reg <= 1'b0;
            end
            if (cmd.walk_start) begin
                active_reg <= 1'b1;
                span_reg   <= 1'b0;
            end
            if (cmd.step_acc && active_reg) begin
                if (last) begin
                    active_reg <= 1'b0;
                end
                if (row_done) begin
                    span_reg <= 1'b0;
                end else if (in_tri) begin
                    span_reg <= 1'b1;
                end
            end
        end
    end

    // restoring divider, one quotient bit per lane per cycle
    always_ff @(posedge aclk) begin
        if (cmd.step_acc) begin
            den_reg <= area_reg[AW-1] ? AW'(-area_reg) : AW'(area_reg);
            for (int k = 0; k < 4; k++) begin
                rem_reg[k] <= ncur_reg[k][NW-1] ? NW'(-ncur_reg[k]) : NW'(ncur_reg[k]);
                neg_reg[k] <= ncur_reg[k][NW-1] ^ area_reg[AW-1];
                q_reg[k]   <= '0;
            end
        end
        if (cmd.div_iter) begin
            for (int k = 0; k < 4; k++) begin
                if (rem_reg[k] >= dsh) begin
                    rem_reg[k]             <= rem_reg[k] - dsh;
                    q_reg[k][cmd.div_bit] <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.step_acc) begin
            if (!active_reg) begin
                out_reg <= '{status: ST_NO_TRI, pixel_x: '0, pixel_y: '0,
                             pixel_color: '0, last_position: 1'b0};
            end else begin
                out_reg <= '{status: in_tri ? ST_INSIDE : ST_OUTSIDE,
                             pixel_x: 11'(curx_reg), pixel_y: 11'(cury_reg),
                             pixel_color: '0, last_position: last};
            end
        end
        if (cmd.out_color) begin
            out_reg.pixel_color <= color;
        end
    end

    assign m_data          = out_reg;
    assign sts.area_zero   = (area_reg == '0);
    assign sts.area_neg    = area_reg[AW-1];
    assign sts.walk_active = active_reg;
    assign sts.in_tri      = in_tri;

endmodule

/* sv/edge_function_triangle_rasterizer_unit.sv */
// Top level: edge-function triangle rasterizer with Gouraud colour.
// Load beat: loading vertex slot 2 runs setup: products and box, area, edge steps, edge
// sums, then multiply, sum, init and row per colour channel. Step beat: outside or no
// triangle answers directly; inside runs the 9-bit restoring division in four lanes.
// One item in flight; the result register lets a load beat in while a result waits.
// Reset (aresetn low, synchronous): no triangle active, no result, culling off.
module edge_function_triangle_rasterizer_unit import efr_pkg::*; #(
    parameter int COORD_BITS = 11
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    // commands from the sequencer, status back from the datapath
    cmd_t cmd;
    sts_t sts;

    // Sequencer: owns the handshakes, the cull register and the channel and division counters.
    efr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: vertex store, setup maths, incremental walkers, divider, result beat.
    efr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

/* sv/efr_checker.sv */
// Port-level checks for the rasterizer, bound to the top level.
module efr_checker import efr_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_no_tri: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NO_TRI |->
            m_data.pixel_x == '0 && m_data.pixel_y == '0
            && m_data.pixel_color == '0 && !m_data.last_position)
        else $error("no-triangle beat carries non-zero fields");

    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OUTSIDE |-> m_data.pixel_color == '0)
        else $error("outside beat carries a colour");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_LOAD && !m_valid |=> !m_valid)
        else $error("load beat produced a result");

endmodule

bind edge_function_triangle_rasterizer_unit efr_checker u_efr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/tb_top.sv */
// Self-checking testbench for the edge-function triangle rasterizer.
`timescale 1ns / 1ps

module tb_top;
    import efr_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int TAIL_CYCLES  = 40;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    edge_function_triangle_rasterizer_unit #(.COORD_BITS(11)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // Predictor state: a shadow copy of the rasterizer, in exact wide integers.
    logic [53:0]    vtx_mem [3];
    longint         step_x [3];
    longint         step_y [3];
    longint         row_val [3];
    longint         cur_val [3];
    longint         plane [12];
    longint         area2;
    longint         box_x0, box_x1, box_y0, box_y1;
    longint         cur_x, cur_y;
    bit             in_span;
    bit             walking;
    bit             cull_mode;

    out_beat_t      pixel_queue [$];
    int             fail_count;
    int             cycle_count;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_off_cycles;

    function automatic longint vtx_x(int i);
        return longint'(vtx_mem[i][10:0]);
    endfunction

    function automatic longint vtx_y(int i);
        return longint'(vtx_mem[i][21:11]);
    endfunction

    function automatic longint vtx_chan(int i, int sh);
        return longint'((vtx_mem[i] >> (22 + sh)) & 54'hFF);
    endfunction

    // Build edges, area, box and colour planes from the three stored vertices.
    function automatic void setup_triangle();
        longint cc [3];
        longint sx [3];
        longint sum;
        longint c0, c1, c2;
        int j;
        int sh;
        sum = 0;
        sx[0] = vtx_x(1) * vtx_y(2) - vtx_x(2) * vtx_y(1);
        sx[1] = vtx_x(2) * vtx_y(0) - vtx_x(0) * vtx_y(2);
        sx[2] = vtx_x(0) * vtx_y(1) - vtx_x(1) * vtx_y(0);
        walking = 1'b0;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            step_x[i] = vtx_y(i) - vtx_y(j);
            step_y[i] = vtx_x(j) - vtx_x(i);
            cc[i] = vtx_x(i) * vtx_y(j) - vtx_x(j) * vtx_y(i);
            sum += cc[i];
        end
        area2 = sum;
        if (sum == 0) return;
        if (sum < 0) begin
            if (cull_mode) return;
            for (int i = 0; i < 3; i++) begin
                step_x[i] = -step_x[i];
                step_y[i] = -step_y[i];
                cc[i] = -cc[i];
            end
        end
        box_x0 = vtx_x(0); box_x1 = vtx_x(0);
        box_y0 = vtx_y(0); box_y1 = vtx_y(0);
        for (int i = 1; i < 3; i++) begin
            if (vtx_x(i) < box_x0) box_x0 = vtx_x(i);
            if (vtx_x(i) > box_x1) box_x1 = vtx_x(i);
            if (vtx_y(i) < box_y0) box_y0 = vtx_y(i);
            if (vtx_y(i) > box_y1) box_y1 = vtx_y(i);
        end
        for (int i = 0; i < 3; i++) begin
            row_val[i] = step_x[i] * box_x0 + step_y[i] * box_y0 + cc[i];
            cur_val[i] = row_val[i];
        end
        for (int k = 0; k < 4; k++) begin
            sh = 24 - 8 * k;
            c0 = vtx_chan(0, sh); c1 = vtx_chan(1, sh); c2 = vtx_chan(2, sh);
            plane[3*k] = vtx_y(0) * (c2 - c1) + vtx_y(1) * (c0 - c2) + vtx_y(2) * (c1 - c0);
            plane[3*k+1] = -(vtx_x(0) * (c2 - c1) + vtx_x(1) * (c0 - c2)
                           + vtx_x(2) * (c1 - c0));
            plane[3*k+2] = c0 * sx[0] + c1 * sx[1] + c2 * sx[2];
        end
        cur_x = box_x0;
        cur_y = box_y0;
        in_span = 1'b0;
        walking = 1'b1;
    endfunction

    function automatic logic [31:0] shade_pixel(longint px, longint py);
        logic [31:0] argb;
        longint num;
        longint q;
        argb = '0;
        for (int k = 0; k < 4; k++) begin
            num = plane[3*k] * px + plane[3*k+1] * py + plane[3*k+2];
            q = (area2 != 0) ? num / area2 : 0;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            argb |= 32'(q) << (24 - 8 * k);
        end
        return argb;
    endfunction

    // Advance the shadow model by one accepted beat and queue any result.
    function automatic void predict_beat(in_beat_t b);
        out_beat_t r;
        bit hit;
        bit row_done;
        if (b.operation == OP_LOAD) begin
            if (b.vertex_slot == SLOT_NONE) return;
            vtx_mem[b.vertex_slot] = {b.vertex_color, b.vertex_y, b.vertex_x};
            if (b.vertex_slot == SLOT_LAST) setup_triangle();
            return;
        end
        r = '0;
        if (!walking) begin
            r.status = ST_NO_TRI;
            pixel_queue.push_back(r);
            return;
        end
        hit = cur_val[0] >= 0 && cur_val[1] >= 0 && cur_val[2] >= 0;
        r.status = hit ? ST_INSIDE : ST_OUTSIDE;
        r.pixel_x = 11'(cur_x);
        r.pixel_y = 11'(cur_y);
        r.pixel_color = hit ? shade_pixel(cur_x, cur_y) : 32'd0;
        row_done = (cur_x >= box_x1) || (!hit && in_span);
        if (hit) in_span = 1'b1;
        if (!row_done) begin
            cur_x++;
            for (int i = 0; i < 3; i++) cur_val[i] += step_x[i];
        end else if (cur_y >= box_y1) begin
            walking = 1'b0;
            r.last_position = 1'b1;
        end else begin
            cur_x = box_x0;
            cur_y++;
            for (int i = 0; i < 3; i++) begin
                row_val[i] += step_y[i];
                cur_val[i] = row_val[i];
            end
            in_span = 1'b0;
        end
        pixel_queue.push_back(r);
    endfunction

    // Send one beat: random idle first, then hold valid until accepted.
    // Valid stays up after acceptance until the next idle or drain drops it.
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predict_beat(b);
    endtask

    task automatic send_load(logic [1:0] slot, logic [10:0] x, logic [10:0] y,
                             logic [31:0] colour);
        in_beat_t b;
        b.operation = OP_LOAD;
        b.vertex_slot = slot;
        b.vertex_x = x;
        b.vertex_y = y;
        b.vertex_color = colour;
        send_beat(b);
    endtask

    task automatic send_step();
        in_beat_t b;
        b = ($bits(in_beat_t))'({$urandom, $urandom});
        b.operation = OP_STEP;
        send_beat(b);
    endtask

    task automatic send_triangle(int unsigned span);
        for (int i = 0; i < 3; i++)
            send_load(2'(i), 11'($urandom_range(span)), 11'($urandom_range(span)), $urandom);
    endtask

    // Walk until the traversal reports its last position, with a cap.
    task automatic walk_out(int cap);
        for (int n = 0; n < cap && walking; n++) send_step();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cull(bit value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cull_mode = value;
        cfg_valid <= 1'b0;
    endtask

    // Result checker: compare each accepted beat with the oldest expectation.
    always @(posedge aclk) begin
        out_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_queue.size() == 0) begin
                $error("unexpected result beat %p", m_data);
                fail_count++;
            end else begin
                e = pixel_queue.pop_front();
                if (m_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_data.status);
                    fail_count++;
                end
                if (m_data.pixel_x !== e.pixel_x) begin
                    $error("pixel_x exp %0d got %0d", e.pixel_x, m_data.pixel_x);
                    fail_count++;
                end
                if (m_data.pixel_y !== e.pixel_y) begin
                    $error("pixel_y exp %0d got %0d", e.pixel_y, m_data.pixel_y);
                    fail_count++;
                end
                if (m_data.pixel_color !== e.pixel_color) begin
                    $error("pixel_color exp %h got %h", e.pixel_color, m_data.pixel_color);
                    fail_count++;
                end
                if (m_data.last_position !== e.last_position) begin
                    $error("last_position exp %0d got %0d", e.last_position,
                           m_data.last_position);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_no_triangle();
        send_step();
        send_step();
        send_load(SLOT_NONE, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF);
        send_step();
    endtask

    task automatic test_directed();
        // small front-facing triangle, full colour extremes
        send_load(2'd0, 11'd0, 11'd0, 32'hFF00_00FF);
        send_load(2'd1, 11'd4, 11'd0, 32'h00FF_0000);
        send_load(2'd2, 11'd0, 11'd3, 32'h0000_FF00);
        walk_out(30);
        // back-facing triangle: edges flipped
        send_load(2'd0, 11'd0, 11'd0, 32'hFFFF_FFFF);
        send_load(2'd1, 11'd0, 11'd2, 32'h0000_0000);
        send_load(2'd2, 11'd3, 11'd0, 32'h1234_5678);
        walk_out(20);
        // degenerate triangle: zero area, steps see no triangle
        send_load(2'd0, 11'd1, 11'd1, 32'h0);
        send_load(2'd1, 11'd2, 11'd2, 32'h0);
        send_load(2'd2, 11'd3, 11'd3, 32'h0);
        send_step();
        // triangle at the far corner of the coordinate range
        send_load(2'd0, 11'h7FF, 11'h7FF, 32'hAAAA_AAAA);
        send_load(2'd1, 11'h7FD, 11'h7FF, 32'h5555_5555);
        send_load(2'd2, 11'h7FF, 11'h7FC, 32'hFFFF_FFFF);
        send_step();
        // reload slots 0 and 1 mid-walk: walk carries on
        send_load(2'd0, 11'd5, 11'd5, 32'h0);
        send_load(2'd1, 11'd9, 11'd5, 32'h0);
        walk_out(20);
    endtask

    task automatic test_culling();
        write_cull(1'b1);
        send_load(2'd0, 11'd0, 11'd0, 32'hFFFF_FFFF);
        send_load(2'd1, 11'd0, 11'd2, 32'h0);
        send_load(2'd2, 11'd3, 11'd0, 32'h0);
        send_step();
        for (int t = 0; t < 6; t++) begin
            send_triangle(6);
            walk_out(60);
        end
        write_cull(1'b0);
    endtask

    // Random triangles: mostly full walks, some interrupted, plus noise beats.
    task automatic test_random(int beats);
        int sent;
        int span;
        sent = 0;
        while (sent < beats) begin
            span = ($urandom_range(19) == 0) ? 2047 : $urandom_range(12);
            case ($urandom_range(9))
                0: begin
                    send_step();
                    sent++;
                end
                1: begin
                    send_load(2'($urandom_range(3)), 11'($urandom), 11'($urandom), $urandom);
                    sent++;
                end
                default: begin
                    send_triangle(span);
                    sent += 3;
                    for (int n = $urandom_range(3) == 0 ? $urandom_range(10) : 80;
                         n > 0 && walking; n--) begin
                        send_step();
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_back_pressure();
        wait_drained();
        hold_off_cycles = 300;
        // fixed front-facing triangle so the walk surely runs into the hold-off
        send_load(2'd0, 11'd0, 11'd0, 32'hFF80_4020);
        send_load(2'd1, 11'd8, 11'd0, 32'h10E0_C0A0);
        send_load(2'd2, 11'd0, 11'd8, 32'h7F01_FF33);
        walk_out(30);
        // pause until the block has returned everything
        wait_drained();
        send_triangle(8);
        walk_out(30);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cull_mode = 1'b0;
        walking = 1'b0;
        area2 = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_no_triangle();
        test_directed();
        test_culling();
        test_random(400);
        send_idle_pct = 62;
        test_random(350);
        write_cull(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        test_random(350);
        write_cull(1'b0);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random(350);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_back_pressure();

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
